[src/assert_macros.svh]
// Assertion macros shared by the files that check themselves.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge.
`define SBMD_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sbmd: invariant violated");

// Same-cycle implication.
`define SBMD_CHECK_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sbmd: implication violated");

// Next-cycle implication.
`define SBMD_CHECK_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sbmd: next-cycle implication violated");

`endif

[src/sbmd_pkg.sv]
// Shared types and constants of the spectral band motion detector.
// Used by every module of the block; depends on nothing.
package sbmd_pkg;

    localparam int NUM_BINS = 128;
    localparam int CNT_W    = $clog2(NUM_BINS + 1);
    localparam int BIN_W    = 7;
    localparam int CMP_W    = (CNT_W > BIN_W) ? CNT_W : BIN_W;
    localparam int LEVEL_W  = 18;
    localparam int LVL_SQ_W = 2 * LEVEL_W;
    localparam int COUNT_W  = 8;
    localparam int DATA_W   = 19;
    localparam int SQ_W     = 2 * DATA_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [COUNT_W-1:0] HITS_MAX = {COUNT_W{1'b1}};

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TREMOR_LOW_BIN   = 3'd0,
        CFG_TREMOR_HIGH_BIN  = 3'd1,
        CFG_DYSK_HIGH_BIN    = 3'd2,
        CFG_TREMOR_LEVEL     = 3'd3,
        CFG_DYSK_LEVEL       = 3'd4,
        CFG_STRONG_LEVEL     = 3'd5,
        CFG_TREMOR_MIN_COUNT = 3'd6,
        CFG_DYSK_MIN_COUNT   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BAND_NONE   = 2'd0,
        BAND_TREMOR = 2'd1,
        BAND_DYSK   = 2'd2
    } band_t;

    typedef struct packed {
        logic [BIN_W-1:0]   tremor_low_bin;
        logic [BIN_W-1:0]   tremor_high_bin;
        logic [BIN_W-1:0]   dyskinesia_high_bin;
        logic [LEVEL_W-1:0] tremor_level;
        logic [LEVEL_W-1:0] dyskinesia_level;
        logic [LEVEL_W-1:0] strong_level;
        logic [COUNT_W-1:0] tremor_min_count;
        logic [COUNT_W-1:0] dyskinesia_min_count;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] mag_re;
        logic [DATA_W-1:0] mag_im;
        band_t             band;
        logic              last;
    } item_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic tremor;
        logic dyskinesia;
        logic strong_hit;
    } res_t;

    typedef struct packed {
        logic                 res_push;
        logic [RES_CNT_W-1:0] res_count;
    } bk_status_t;

endpackage

[src/sbmd_front.sv]
// Front end: accepts bins, tracks the bin index, takes magnitudes of both parts
// and tags each bin with its band. Depends on sbmd_pkg.
module sbmd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbmd_pkg::cfg_t              cfg,
    input  logic                        push,
    input  logic signed [sbmd_pkg::DATA_W-1:0] bin_real,
    input  logic signed [sbmd_pkg::DATA_W-1:0] bin_imag,
    input  logic                        last_bin,
    input  logic                        q_full,
    output logic                        q_push,
    output sbmd_pkg::item_t             q_item
);

    logic [sbmd_pkg::CNT_W-1:0] bin_cnt_reg;
    logic [sbmd_pkg::CNT_W-1:0] bin_cnt_next;
    logic [sbmd_pkg::CMP_W-1:0] idx;
    logic [sbmd_pkg::CMP_W-1:0] low_bin;
    logic [sbmd_pkg::CMP_W-1:0] high_bin;
    logic [sbmd_pkg::CMP_W-1:0] dysk_bin;
    logic                       in_range;
    logic [sbmd_pkg::DATA_W-1:0] re_u;
    logic [sbmd_pkg::DATA_W-1:0] im_u;

    assign q_push   = push && !q_full;
    assign in_range = (bin_cnt_reg < sbmd_pkg::CNT_W'(sbmd_pkg::NUM_BINS));
    assign idx      = sbmd_pkg::CMP_W'(bin_cnt_reg);
    assign low_bin  = sbmd_pkg::CMP_W'(cfg.tremor_low_bin);
    assign high_bin = sbmd_pkg::CMP_W'(cfg.tremor_high_bin);
    assign dysk_bin = sbmd_pkg::CMP_W'(cfg.dyskinesia_high_bin);

    // The most negative input has a magnitude that still fits unsigned.
    assign re_u = bin_real;
    assign im_u = bin_imag;

    always_comb
    begin
        q_item.mag_re = bin_real[sbmd_pkg::DATA_W-1] ? (~re_u + 1'b1) : re_u;
        q_item.mag_im = bin_imag[sbmd_pkg::DATA_W-1] ? (~im_u + 1'b1) : im_u;
        q_item.last   = last_bin;
        // The DC bin and bins past the frame length belong to no band.
        if (!in_range || idx == '0)
        begin
            q_item.band = sbmd_pkg::BAND_NONE;
        end
        else if (idx >= low_bin && idx <= high_bin)
        begin
            q_item.band = sbmd_pkg::BAND_TREMOR;
        end
        else if (idx > high_bin && idx <= dysk_bin)
        begin
            q_item.band = sbmd_pkg::BAND_DYSK;
        end
        else
        begin
            q_item.band = sbmd_pkg::BAND_NONE;
        end
    end

    always_comb
    begin
        bin_cnt_next = bin_cnt_reg;
        if (q_push)
        begin
            if (last_bin)
            begin
                bin_cnt_next = '0;
            end
            else if (in_range)
            begin
                bin_cnt_next = bin_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg <= '0;
        end
        else
        begin
            bin_cnt_reg <= bin_cnt_next;
        end
    end

endmodule

[src/sbmd_queue.sv]
// Short queue of classified bins between the front end and the back end.
// Depends on sbmd_pkg.
module sbmd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  sbmd_pkg::item_t       wr_item,
    input  logic                  rd_en,
    output sbmd_pkg::item_t       rd_item,
    output sbmd_pkg::q_status_t   status
);

    sbmd_pkg::item_t               mem_reg [sbmd_pkg::Q_DEPTH];
    logic [sbmd_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [sbmd_pkg::Q_PTR_W-1:0]  wr_ptr_next;
    logic [sbmd_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [sbmd_pkg::Q_PTR_W-1:0]  rd_ptr_next;
    logic [sbmd_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic [sbmd_pkg::Q_CNT_W-1:0]  cnt_next;

    assign rd_item      = mem_reg[rd_ptr_reg];
    assign status.count = cnt_reg;
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == sbmd_pkg::Q_CNT_W'(sbmd_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == sbmd_pkg::Q_PTR_W'(sbmd_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == sbmd_pkg::Q_PTR_W'(sbmd_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/sbmd_back.sv]
// Back end: squares the magnitudes, updates band hit counts and peaks, and at
// the last bin of a frame queues the three flags. Depends on sbmd_pkg.
module sbmd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbmd_pkg::cfg_t         cfg,
    input  sbmd_pkg::item_t        q_item,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic                   tremor_flag,
    output logic                   dyskinesia_flag,
    output logic                   strong_flag,
    output sbmd_pkg::bk_status_t   status
);

    logic [sbmd_pkg::LVL_SQ_W-1:0] trem_lvl_sq_reg;
    logic [sbmd_pkg::LVL_SQ_W-1:0] dysk_lvl_sq_reg;
    logic [sbmd_pkg::LVL_SQ_W-1:0] strong_lvl_sq_reg;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [sbmd_pkg::SQ_W-1:0]   s1_re_sq_reg;
    logic [sbmd_pkg::SQ_W-1:0]   s1_im_sq_reg;
    sbmd_pkg::band_t             s1_band_reg;
    logic                        s1_last_reg;

    logic [sbmd_pkg::COUNT_W-1:0] trem_hits_reg;
    logic [sbmd_pkg::COUNT_W-1:0] trem_hits_next;
    logic [sbmd_pkg::COUNT_W-1:0] dysk_hits_reg;
    logic [sbmd_pkg::COUNT_W-1:0] dysk_hits_next;
    logic [sbmd_pkg::SQ_W-1:0]    trem_peak_reg;
    logic [sbmd_pkg::SQ_W-1:0]    trem_peak_next;
    logic [sbmd_pkg::SQ_W-1:0]    dysk_peak_reg;
    logic [sbmd_pkg::SQ_W-1:0]    dysk_peak_next;

    logic [sbmd_pkg::SQ_W-1:0]    mag_sq;
    logic [sbmd_pkg::SQ_W-1:0]    re_ext;
    logic [sbmd_pkg::SQ_W-1:0]    im_ext;
    logic                         advance;
    logic                         acc_fire;
    logic                         trem_det;
    logic                         dysk_det;
    sbmd_pkg::res_t               res_word;

    sbmd_pkg::res_t                  res_mem_reg [sbmd_pkg::RES_DEPTH];
    logic [sbmd_pkg::RES_PTR_W-1:0]  res_wr_ptr_reg;
    logic [sbmd_pkg::RES_PTR_W-1:0]  res_rd_ptr_reg;
    logic [sbmd_pkg::RES_CNT_W-1:0]  res_cnt_reg;
    logic [sbmd_pkg::RES_CNT_W-1:0]  res_cnt_next;
    logic                            res_full;
    logic                            res_push;
    logic                            res_pop;

    assign res_full = (res_cnt_reg == sbmd_pkg::RES_CNT_W'(sbmd_pkg::RES_DEPTH));
    assign res_push = acc_fire && s1_last_reg;
    assign res_pop  = pop && !empty;
    assign empty    = (res_cnt_reg == '0);

    // The pipeline only waits when a frame ends and the result queue is full.
    assign advance  = !(s1_valid_reg && s1_last_reg && res_full);
    assign q_pop    = advance && !q_empty;
    assign acc_fire = advance && s1_valid_reg;
    assign s1_valid_next = advance ? !q_empty : s1_valid_reg;

    assign re_ext = sbmd_pkg::SQ_W'(q_item.mag_re);
    assign im_ext = sbmd_pkg::SQ_W'(q_item.mag_im);
    assign mag_sq = s1_re_sq_reg + s1_im_sq_reg;

    // The user must change levels only while the block is idle; the block itself
    // does not enforce this. Their squares are simply recomputed every cycle.
    always_ff @(posedge clk)
    begin
        trem_lvl_sq_reg   <= sbmd_pkg::LVL_SQ_W'(cfg.tremor_level)
                             * sbmd_pkg::LVL_SQ_W'(cfg.tremor_level);
        dysk_lvl_sq_reg   <= sbmd_pkg::LVL_SQ_W'(cfg.dyskinesia_level)
                             * sbmd_pkg::LVL_SQ_W'(cfg.dyskinesia_level);
        strong_lvl_sq_reg <= sbmd_pkg::LVL_SQ_W'(cfg.strong_level)
                             * sbmd_pkg::LVL_SQ_W'(cfg.strong_level);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_re_sq_reg <= re_ext * re_ext;
            s1_im_sq_reg <= im_ext * im_ext;
            s1_band_reg  <= q_item.band;
            s1_last_reg  <= q_item.last;
        end
    end

    always_comb
    begin
        trem_hits_next = trem_hits_reg;
        dysk_hits_next = dysk_hits_reg;
        trem_peak_next = trem_peak_reg;
        dysk_peak_next = dysk_peak_reg;
        unique case (s1_band_reg)
            sbmd_pkg::BAND_TREMOR:
            begin
                if (mag_sq >= sbmd_pkg::SQ_W'(trem_lvl_sq_reg)
                    && trem_hits_reg != sbmd_pkg::HITS_MAX)
                begin
                    trem_hits_next = trem_hits_reg + 1'b1;
                end
                if (mag_sq > trem_peak_reg)
                begin
                    trem_peak_next = mag_sq;
                end
            end
            sbmd_pkg::BAND_DYSK:
            begin
                if (mag_sq >= sbmd_pkg::SQ_W'(dysk_lvl_sq_reg)
                    && dysk_hits_reg != sbmd_pkg::HITS_MAX)
                begin
                    dysk_hits_next = dysk_hits_reg + 1'b1;
                end
                if (mag_sq > dysk_peak_reg)
                begin
                    dysk_peak_next = mag_sq;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign trem_det            = (trem_hits_next >= cfg.tremor_min_count);
    assign dysk_det            = (dysk_hits_next >= cfg.dyskinesia_min_count);
    assign res_word.tremor     = trem_det || dysk_det;
    assign res_word.dyskinesia = !trem_det && dysk_det;
    assign res_word.strong_hit = (trem_peak_next >= sbmd_pkg::SQ_W'(strong_lvl_sq_reg))
                              || (dysk_peak_next >= sbmd_pkg::SQ_W'(strong_lvl_sq_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            trem_hits_reg <= '0;
            dysk_hits_reg <= '0;
            trem_peak_reg <= '0;
            dysk_peak_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (acc_fire)
            begin
                if (s1_last_reg)
                begin
                    trem_hits_reg <= '0;
                    dysk_hits_reg <= '0;
                    trem_peak_reg <= '0;
                    dysk_peak_reg <= '0;
                end
                else
                begin
                    trem_hits_reg <= trem_hits_next;
                    dysk_hits_reg <= dysk_hits_next;
                    trem_peak_reg <= trem_peak_next;
                    dysk_peak_reg <= dysk_peak_next;
                end
            end
        end
    end

    // Result queue.
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_ptr_reg] <= res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_ptr_reg <= (res_wr_ptr_reg == sbmd_pkg::RES_PTR_W'(sbmd_pkg::RES_DEPTH - 1))
                                  ? '0 : res_wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= (res_rd_ptr_reg == sbmd_pkg::RES_PTR_W'(sbmd_pkg::RES_DEPTH - 1))
                                  ? '0 : res_rd_ptr_reg + 1'b1;
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

    assign tremor_flag      = res_mem_reg[res_rd_ptr_reg].tremor;
    assign dyskinesia_flag  = res_mem_reg[res_rd_ptr_reg].dyskinesia;
    assign strong_flag      = res_mem_reg[res_rd_ptr_reg].strong_hit;
    assign status.res_push  = res_push;
    assign status.res_count = res_cnt_reg;

endmodule

[src/spectral_band_motion_detector_core.sv]
// Spectral band motion detector: one FFT bin accepted per cycle while not full.
// The flags of a frame reach the outputs after its last bin has passed the queue,
// the squaring stage and the accumulate stage into the result queue.
// Stalls come only from the result queue when a frame ends with it full.
// rst_n is asynchronous and clears all queues, counters and accumulators and
// loads the configuration registers with their defaults.
`include "assert_macros.svh"

module spectral_band_motion_detector_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [sbmd_pkg::DATA_W-1:0]  bin_real,
    input  logic signed [sbmd_pkg::DATA_W-1:0]  bin_imag,
    input  logic                                last_bin,
    output logic                                empty,
    input  logic                                pop,
    output logic                                tremor_flag,
    output logic                                dyskinesia_flag,
    output logic                                strong_flag
);

    sbmd_pkg::cfg_t        cfg_reg;
    sbmd_pkg::item_t       fe_item;
    sbmd_pkg::item_t       bk_item;
    sbmd_pkg::q_status_t   q_stat;
    sbmd_pkg::bk_status_t  bk_stat;
    logic                  q_push;
    logic                  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tremor_low_bin       <= 7'd8;
            cfg_reg.tremor_high_bin      <= 7'd12;
            cfg_reg.dyskinesia_high_bin  <= 7'd17;
            cfg_reg.tremor_level         <= 18'd3584;
            cfg_reg.dyskinesia_level     <= 18'd5120;
            cfg_reg.strong_level         <= 18'd20480;
            cfg_reg.tremor_min_count     <= 8'd2;
            cfg_reg.dyskinesia_min_count <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sbmd_pkg::cfg_idx_t'(cfg_index))
                sbmd_pkg::CFG_TREMOR_LOW_BIN:
                    cfg_reg.tremor_low_bin <= cfg_data[sbmd_pkg::BIN_W-1:0];
                sbmd_pkg::CFG_TREMOR_HIGH_BIN:
                    cfg_reg.tremor_high_bin <= cfg_data[sbmd_pkg::BIN_W-1:0];
                sbmd_pkg::CFG_DYSK_HIGH_BIN:
                    cfg_reg.dyskinesia_high_bin <= cfg_data[sbmd_pkg::BIN_W-1:0];
                sbmd_pkg::CFG_TREMOR_LEVEL:
                    cfg_reg.tremor_level <= cfg_data[sbmd_pkg::LEVEL_W-1:0];
                sbmd_pkg::CFG_DYSK_LEVEL:
                    cfg_reg.dyskinesia_level <= cfg_data[sbmd_pkg::LEVEL_W-1:0];
                sbmd_pkg::CFG_STRONG_LEVEL:
                    cfg_reg.strong_level <= cfg_data[sbmd_pkg::LEVEL_W-1:0];
                sbmd_pkg::CFG_TREMOR_MIN_COUNT:
                    cfg_reg.tremor_min_count <= cfg_data[sbmd_pkg::COUNT_W-1:0];
                sbmd_pkg::CFG_DYSK_MIN_COUNT:
                    cfg_reg.dyskinesia_min_count <= cfg_data[sbmd_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sbmd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .bin_real (bin_real),
        .bin_imag (bin_imag),
        .last_bin (last_bin),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_item   (fe_item)
    );

    sbmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (fe_item),
        .rd_en   (q_pop),
        .rd_item (bk_item),
        .status  (q_stat)
    );

    sbmd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_item          (bk_item),
        .q_empty         (q_stat.empty),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .tremor_flag     (tremor_flag),
        .dyskinesia_flag (dyskinesia_flag),
        .strong_flag     (strong_flag),
        .status          (bk_stat)
    );

    assign full = q_stat.full;

    `SBMD_CHECK_NEXT(a_q_fill, (push && !full && !q_pop), (q_stat.count == $past(q_stat.count) + 1'b1))
    `SBMD_CHECK_NEXT(a_q_drain, (q_pop && !(push && !full)), (q_stat.count == $past(q_stat.count) - 1'b1))
    `SBMD_CHECK_NEXT(a_res_drain, (pop && !empty && bk_stat.res_count == 2'd1 && !bk_stat.res_push), empty)
    `SBMD_CHECK_IMPL(a_pop_needs_item, q_pop, !q_stat.empty)

endmodule
